>>> rtl/fftfd_pkg.sv
`timescale 1ns / 1ps
// Package for the stop-bit template field decoder.
// Holds widths, field position codes and the state and result structs.
// No dependencies.
package fftfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAYLOAD_W   = 7;
    localparam int VALUE_W     = 63;
    localparam int CODE_W      = 4;
    localparam int TEMPLATE_W  = 14;
    localparam int GROUP_W     = 4;

    localparam int MAX_INT_BYTES_DEF = 9;

    localparam logic [TEMPLATE_W-1:0] TEMPLATE_RESET = TEMPLATE_W'(1);
    localparam logic [GROUP_W-1:0]    GROUP_MAX      = '1;

    // Field position; its value doubles as the reported field code.
    typedef enum logic [CODE_W-1:0] {
        POS_SEQ      = 4'd0,
        POS_PMAP     = 4'd1,
        POS_TEMPLATE = 4'd2,
        POS_SYMBOL   = 4'd3,
        POS_TYPE     = 4'd4,
        POS_PRICE    = 4'd5,
        POS_SIZE     = 4'd6,
        POS_TIME     = 4'd7,
        POS_UNKNOWN  = 4'd8
    } field_pos_t;

    typedef struct packed {
        field_pos_t           pos;
        logic [VALUE_W-1:0]   acc;
        logic [GROUP_W-1:0]   groups;
        logic                 ovf;
    } dec_state_t;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [VALUE_W-1:0]   value;
        logic                 is_char;
        logic                 last;
        logic                 overflow;
    } dec_result_t;

endpackage

>>> rtl/fftfd_field_step.sv
`timescale 1ns / 1ps
// One decode step: next field state and the optional result for one byte.
// Depends on fftfd_pkg.
module fftfd_field_step #(
    parameter int MaxIntBytes = fftfd_pkg::MAX_INT_BYTES_DEF
) (
    input  fftfd_pkg::dec_state_t                    state,
    input  logic [fftfd_pkg::BYTE_W-1:0]             data_byte,
    input  logic                                     start_of_message,
    input  logic [fftfd_pkg::TEMPLATE_W-1:0]         handled_template,
    output fftfd_pkg::dec_state_t                    state_next,
    output logic                                     res_valid,
    output fftfd_pkg::dec_result_t                   result
);

    localparam logic [fftfd_pkg::GROUP_W-1:0] GroupLimit =
        fftfd_pkg::GROUP_W'(MaxIntBytes);

    fftfd_pkg::dec_state_t                 cur;
    logic                                  stop;
    logic [fftfd_pkg::PAYLOAD_W-1:0]       payload;
    logic [fftfd_pkg::VALUE_W-1:0]         acc_shift;
    logic                                  ovf_upd;
    logic [fftfd_pkg::GROUP_W-1:0]         groups_upd;
    logic                                  tmpl_match;

    assign stop    = data_byte[fftfd_pkg::BYTE_W-1];
    assign payload = data_byte[fftfd_pkg::PAYLOAD_W-1:0];

    // Start of message drops any partial field.
    always_comb
    begin
        if (start_of_message)
        begin
            cur.pos    = fftfd_pkg::POS_SEQ;
            cur.acc    = '0;
            cur.groups = '0;
            cur.ovf    = 1'b0;
        end
        else
        begin
            cur = state;
        end
    end

    assign acc_shift  = {cur.acc[fftfd_pkg::VALUE_W-fftfd_pkg::PAYLOAD_W-1:0], payload};
    assign ovf_upd    = cur.ovf | (cur.groups >= GroupLimit);
    assign groups_upd = (cur.groups == fftfd_pkg::GROUP_MAX) ? cur.groups
                                                            : cur.groups + fftfd_pkg::GROUP_W'(1);
    assign tmpl_match = (acc_shift ==
        {{(fftfd_pkg::VALUE_W-fftfd_pkg::TEMPLATE_W){1'b0}}, handled_template});

    always_comb
    begin
        state_next      = cur;
        res_valid       = 1'b0;
        result.code     = cur.pos;
        result.value    = acc_shift;
        result.is_char  = 1'b0;
        result.last     = 1'b1;
        result.overflow = ovf_upd;

        if (cur.pos inside {fftfd_pkg::POS_SYMBOL, fftfd_pkg::POS_TIME})
        begin
            // String field: one character per byte.
            res_valid       = 1'b1;
            result.value    = {{(fftfd_pkg::VALUE_W-fftfd_pkg::PAYLOAD_W){1'b0}}, payload};
            result.is_char  = 1'b1;
            result.last     = stop;
            result.overflow = 1'b0;
            if (stop)
            begin
                state_next.pos = (cur.pos == fftfd_pkg::POS_SYMBOL) ? fftfd_pkg::POS_TYPE
                                                                    : fftfd_pkg::POS_SEQ;
            end
        end
        else if (!stop)
        begin
            // Integer field: gather the group, no result yet.
            state_next.acc    = acc_shift;
            state_next.groups = groups_upd;
            state_next.ovf    = ovf_upd;
        end
        else
        begin
            res_valid         = 1'b1;
            state_next.acc    = '0;
            state_next.groups = '0;
            state_next.ovf    = 1'b0;
            case (cur.pos)
                fftfd_pkg::POS_SEQ:      state_next.pos = fftfd_pkg::POS_PMAP;
                fftfd_pkg::POS_PMAP:     state_next.pos = fftfd_pkg::POS_TEMPLATE;
                fftfd_pkg::POS_TEMPLATE: state_next.pos = tmpl_match ? fftfd_pkg::POS_SYMBOL
                                                                     : fftfd_pkg::POS_UNKNOWN;
                fftfd_pkg::POS_TYPE:     state_next.pos = fftfd_pkg::POS_PRICE;
                fftfd_pkg::POS_PRICE:    state_next.pos = fftfd_pkg::POS_SIZE;
                fftfd_pkg::POS_SIZE:     state_next.pos = fftfd_pkg::POS_TIME;
                default:                 state_next.pos = fftfd_pkg::POS_UNKNOWN;
            endcase
        end
    end

endmodule

>>> rtl/fftfd_out_buffer.sv
`timescale 1ns / 1ps
// Two-entry output register with skid slot for decoded results.
// Depends on fftfd_pkg.
module fftfd_out_buffer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fftfd_pkg::dec_result_t  push_data,
    output logic                    space,
    output logic                    out_valid,
    input  logic                    out_ready,
    output fftfd_pkg::dec_result_t  out_data
);

    logic                   main_valid_reg, main_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    fftfd_pkg::dec_result_t main_data_reg,  main_data_next;
    fftfd_pkg::dec_result_t skid_data_reg,  skid_data_next;
    logic                   pop;

    assign pop       = main_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (main_valid_reg)
        begin
            if (push && pop)
            begin
                main_data_next = push_data;
            end
            else if (push)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else if (pop)
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            main_data_next  = push_data;
            main_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/fast_fixed_template_field_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the stop-bit template field decoder.
// Depends on fftfd_pkg, fftfd_field_step and fftfd_out_buffer.
//
// Usage:
//   Input channel: one stream byte per beat (data_byte, start_of_message)
//   on in_valid/in_ready. Bit 7 of a byte ends the current field.
//   Output channel: one decoded result per beat (field_code, field_value,
//   is_char, last, overflow) on out_valid/out_ready. Integer bytes without
//   the stop bit produce no beat; string bytes produce one beat each.
//   Configuration: cfg_write_en writes cfg_write_data into the handled
//   template id at the clock edge; write only while the block is idle.
// Timing:
//   One byte per cycle sustained while in_ready is high. A result is registered
//   in the output buffer when its byte is taken; a single step of combinational
//   field logic lies between the field state registers and the output register.
// Reset:
//   rst_n clears the field state to the sequence number field and sets the
//   handled template id to 1; the output holds no beat.
// Stall:
//   While the receiver holds out_ready low, one more result parks in a skid
//   slot; in_ready then drops until the output drains.
module fast_fixed_template_field_decoder_unit #(
    parameter int MaxIntBytes = fftfd_pkg::MAX_INT_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [fftfd_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                  start_of_message,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fftfd_pkg::CODE_W-1:0]          field_code,
    output logic [fftfd_pkg::VALUE_W-1:0]         field_value,
    output logic                                  is_char,
    output logic                                  last,
    output logic                                  overflow,
    input  logic                                  cfg_write_en,
    input  logic [fftfd_pkg::TEMPLATE_W-1:0]      cfg_write_data
);

    fftfd_pkg::dec_state_t              state_reg, state_next;
    logic [fftfd_pkg::TEMPLATE_W-1:0]   template_reg;
    logic                               in_accept;
    logic                               res_valid;
    fftfd_pkg::dec_result_t             step_result;
    fftfd_pkg::dec_result_t             out_data;

    assign in_accept = in_valid & in_ready;

    // Advance the field state only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos    <= fftfd_pkg::POS_SEQ;
            state_reg.acc    <= '0;
            state_reg.groups <= '0;
            state_reg.ovf    <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            template_reg <= fftfd_pkg::TEMPLATE_RESET;
        end
        else if (cfg_write_en)
        begin
            template_reg <= cfg_write_data;
        end
    end

    fftfd_field_step #(
        .MaxIntBytes (MaxIntBytes)
    ) u_step (
        .state            (state_reg),
        .data_byte        (data_byte),
        .start_of_message (start_of_message),
        .handled_template (template_reg),
        .state_next       (state_next),
        .res_valid        (res_valid),
        .result           (step_result)
    );

    // Push a result only for a taken byte that ends or carries a character.
    fftfd_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept & res_valid),
        .push_data (step_result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign field_code  = out_data.code;
    assign field_value = out_data.value;
    assign is_char     = out_data.is_char;
    assign last        = out_data.last;
    assign overflow    = out_data.overflow;

    // Skid slot fills only behind a held output beat.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("skid slot full while output register empty");

    // Characters come only from string fields and never flag overflow.
    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_char |-> !overflow &&
            (field_code == fftfd_pkg::POS_SYMBOL || field_code == fftfd_pkg::POS_TIME))
        else $error("character beat from a non-string field");

    // Integer results always close their field.
    a_int_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_char |-> last)
        else $error("integer result without last");

    // An empty gather has no value and no overflow.
    a_clear_field: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.groups == '0 |-> state_reg.acc == '0 && !state_reg.ovf)
        else $error("field state not cleared");

    // Start of message always restarts at the sequence number field.
    a_som_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && start_of_message && !data_byte[fftfd_pkg::BYTE_W-1]
            |=> state_reg.pos == fftfd_pkg::POS_SEQ)
        else $error("start of message did not restart decoding");

endmodule

>>> dv/fftfd_field_checker.sv
`timescale 1ns / 1ps
// Result checker for the stop-bit template field decoder: tracks field state
// from the accepted input beats and compares every output beat in order.
// Depends on fftfd_pkg.
module fftfd_field_checker #(
    parameter int MaxIntBytes = fftfd_pkg::MAX_INT_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [fftfd_pkg::BYTE_W-1:0]        data_byte,
    input  logic                                start_of_message,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [fftfd_pkg::CODE_W-1:0]        field_code,
    input  logic [fftfd_pkg::VALUE_W-1:0]       field_value,
    input  logic                                is_char,
    input  logic                                last,
    input  logic                                overflow,
    input  logic                                cfg_write_en,
    input  logic [fftfd_pkg::TEMPLATE_W-1:0]    cfg_write_data,
    output int                                  mismatches,
    output int                                  fields_pending
);

    localparam logic [fftfd_pkg::GROUP_W-1:0] GroupLimit =
        fftfd_pkg::GROUP_W'(MaxIntBytes);

    fftfd_pkg::field_pos_t                 cur_pos;
    logic [fftfd_pkg::VALUE_W-1:0]         acc;
    logic [fftfd_pkg::GROUP_W-1:0]         groups;
    logic                                  ovf_seen;
    logic [fftfd_pkg::TEMPLATE_W-1:0]      tmpl;

    fftfd_pkg::dec_result_t                expected_fields[$];
    fftfd_pkg::dec_result_t                want;
    fftfd_pkg::dec_result_t                got;

    // Advance the field state by one stream byte; return 1 when it yields a result.
    function automatic bit decode_byte(input logic [fftfd_pkg::BYTE_W-1:0] b,
                                       input logic sop,
                                       output fftfd_pkg::dec_result_t r);
        fftfd_pkg::field_pos_t             p;
        logic                              stop;
        logic [fftfd_pkg::PAYLOAD_W-1:0]   pay;
        stop = b[fftfd_pkg::BYTE_W-1];
        pay  = b[fftfd_pkg::PAYLOAD_W-1:0];
        r    = '0;
        if (sop)
        begin
            cur_pos  = fftfd_pkg::POS_SEQ;
            acc      = '0;
            groups   = '0;
            ovf_seen = 1'b0;
        end
        p = (cur_pos > fftfd_pkg::POS_UNKNOWN) ? fftfd_pkg::POS_UNKNOWN : cur_pos;

        // string fields: one character per byte
        if (p == fftfd_pkg::POS_SYMBOL || p == fftfd_pkg::POS_TIME)
        begin
            r.code    = p;
            r.value   = fftfd_pkg::VALUE_W'(pay);
            r.is_char = 1'b1;
            r.last    = stop;
            if (stop)
                cur_pos = (p == fftfd_pkg::POS_SYMBOL) ? fftfd_pkg::POS_TYPE
                                                       : fftfd_pkg::POS_SEQ;
            return 1'b1;
        end

        if (groups >= GroupLimit)
            ovf_seen = 1'b1;
        acc = {acc[fftfd_pkg::VALUE_W-fftfd_pkg::PAYLOAD_W-1:0], pay};
        if (groups != fftfd_pkg::GROUP_MAX)
            groups = groups + fftfd_pkg::GROUP_W'(1);
        if (!stop)
            return 1'b0;

        r.code     = p;
        r.value    = acc;
        r.last     = 1'b1;
        r.overflow = ovf_seen;
        case (p)
            fftfd_pkg::POS_SEQ:      cur_pos = fftfd_pkg::POS_PMAP;
            fftfd_pkg::POS_PMAP:     cur_pos = fftfd_pkg::POS_TEMPLATE;
            fftfd_pkg::POS_TEMPLATE: cur_pos = (acc == fftfd_pkg::VALUE_W'(tmpl))
                                               ? fftfd_pkg::POS_SYMBOL
                                               : fftfd_pkg::POS_UNKNOWN;
            fftfd_pkg::POS_TYPE:     cur_pos = fftfd_pkg::POS_PRICE;
            fftfd_pkg::POS_PRICE:    cur_pos = fftfd_pkg::POS_SIZE;
            fftfd_pkg::POS_SIZE:     cur_pos = fftfd_pkg::POS_TIME;
            default:                 cur_pos = fftfd_pkg::POS_UNKNOWN;
        endcase
        acc      = '0;
        groups   = '0;
        ovf_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_error(input string what, input fftfd_pkg::dec_result_t w,
                                input fftfd_pkg::dec_result_t g);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected code=%0d value=%0h char=%0b last=%0b ovf=%0b,",
                      " got code=%0d value=%0h char=%0b last=%0b ovf=%0b"},
                     $realtime, what, w.code, w.value, w.is_char, w.last, w.overflow,
                     g.code, g.value, g.is_char, g.last, g.overflow);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos        = fftfd_pkg::POS_SEQ;
            acc            = '0;
            groups         = '0;
            ovf_seen       = 1'b0;
            tmpl           = fftfd_pkg::TEMPLATE_RESET;
            mismatches     = 0;
            fields_pending = 0;
            expected_fields.delete();
        end
        else
        begin
            if (cfg_write_en)
                tmpl = cfg_write_data;
            if (in_valid && in_ready)
            begin
                if (decode_byte(data_byte, start_of_message, want))
                    expected_fields.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{code: field_code, value: field_value, is_char: is_char,
                        last: last, overflow: overflow};
                if (expected_fields.size() == 0)
                    report_error("unexpected result", '0, got);
                else
                begin
                    want = expected_fields.pop_front();
                    if (got.code !== want.code || got.value !== want.value ||
                        got.is_char !== want.is_char || got.last !== want.last ||
                        got.overflow !== want.overflow)
                        report_error("wrong result", want, got);
                end
            end
            fields_pending = expected_fields.size();
        end
    end

endmodule

>>> dv/tb_fast_fixed_template_field_decoder_unit.sv
`timescale 1ns / 1ps
// Testbench top for the stop-bit template field decoder: drives byte streams,
// template settings and output back-pressure, and prints the verdict.
// Depends on fftfd_pkg, the decoder RTL and fftfd_field_checker.
module tb_fast_fixed_template_field_decoder_unit;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [fftfd_pkg::BYTE_W-1:0]         data_byte;
    logic                                 start_of_message;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [fftfd_pkg::CODE_W-1:0]         field_code;
    logic [fftfd_pkg::VALUE_W-1:0]        field_value;
    logic                                 is_char;
    logic                                 last;
    logic                                 overflow;
    logic                                 cfg_write_en;
    logic [fftfd_pkg::TEMPLATE_W-1:0]     cfg_write_data;

    int mismatches;
    int fields_pending;

    // Stimulus knobs: chance in percent of starting an idle burst on each side.
    int gap_pct   = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    // Bytes left before a broken message is cut short; negative means no cut.
    int cut_left = -1;
    logic [fftfd_pkg::TEMPLATE_W-1:0] cur_template = fftfd_pkg::TEMPLATE_RESET;

    fast_fixed_template_field_decoder_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .field_code       (field_code),
        .field_value      (field_value),
        .is_char          (is_char),
        .last             (last),
        .overflow         (overflow),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data)
    );

    fftfd_field_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .start_of_message (start_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .field_code       (field_code),
        .field_value      (field_value),
        .is_char          (is_char),
        .last             (last),
        .overflow         (overflow),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .mismatches       (mismatches),
        .fields_pending   (fields_pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #10_000_000;
        $display("fast_fixed_template_field_decoder_unit: mismatch");
        $finish;
    end

    // Receiver back-pressure: drop out_ready in bursts, each started with chance stall_pct.
    initial
    begin : ready_gen
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready = 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                hold = $urandom_range(0, 6);
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    // Send one stream byte. Called and returns at a falling edge; valid stays
    // high into the next beat unless an idle burst is drawn.
    task automatic send_byte(input logic [7:0] b, input logic sop);
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid         = 1'b1;
        data_byte        = b;
        start_of_message = sop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Integer field of n groups, most significant first. Groups above bit 62
    // carry random payload, since the decoder shifts them out anyway.
    task automatic send_int(input logic [62:0] v, input int n, input logic sop);
        int                 i;
        int                 sh;
        logic [6:0]         pay;
        for (i = 0; i < n; i++)
        begin
            sh  = 7 * (n - 1 - i);
            pay = (sh < 63) ? 7'(v >> sh) : 7'($urandom);
            send_byte({i == n - 1, pay}, sop && i == 0);
        end
    endtask

    task automatic send_str(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte({i == n - 1, 7'($urandom)}, 1'b0);
    endtask

    // Mostly short integers, some full width, a few past the overflow point.
    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 90)
            return $urandom_range(4, 9);
        return $urandom_range(10, 12);
    endfunction

    function automatic logic [62:0] rand_val();
        return 63'({$urandom, $urandom});
    endfunction

    // One message; a hit uses the handled template id and walks every named
    // field, a miss sends a few fields that decode as unknown.
    task automatic send_message(input bit broken);
        bit                 hit;
        int                 k;
        int                 n;
        logic [62:0]        tid;
        cut_left = broken ? $urandom_range(1, 14) : -1;
        hit = $urandom_range(99) < 80;
        send_int(rand_val(), rand_len(), $urandom_range(3) != 0);
        send_int(rand_val(), rand_len(), 1'b0);
        if (hit)
        begin
            // allow one redundant leading zero group
            n = ((cur_template < 128) ? 1 : 2) + $urandom_range(0, 1);
            send_int(63'(cur_template), n, 1'b0);
            send_str($urandom_range(1, 8));
            send_int(rand_val(), rand_len(), 1'b0);
            send_int(rand_val(), rand_len(), 1'b0);
            send_int(rand_val(), rand_len(), 1'b0);
            send_str($urandom_range(1, 10));
        end
        else
        begin
            if ($urandom_range(1))
                tid = 63'(cur_template ^ (14'd1 << $urandom_range(13)));
            else
                tid = 63'(cur_template) + 63'(14'h3FFF + $urandom_range(1, 1000));
            send_int(tid, (tid < 128) ? 1 : ((tid < 16384) ? 2 : 3), 1'b0);
            for (k = $urandom_range(0, 4); k > 0; k--)
                send_int(rand_val(), rand_len(), 1'b0);
        end
        cut_left = -1;
    endtask

    // Raw bytes with the odd start_of_message, often mid-field.
    task automatic send_noise();
        int k;
        for (k = $urandom_range(1, 8); k > 0; k--)
            send_byte(8'($urandom), $urandom_range(99) < 10);
    endtask

    // Hold the sender until every result is out, let the last integer byte
    // clear the pipe, then write the template id.
    task automatic set_template(input logic [13:0] t);
        in_valid = 1'b0;
        while (fields_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = t;
        @(negedge clk);
        cfg_write_en   = 1'b0;
        cur_template   = t;
    endtask

    initial
    begin : stim
        int                 ph;
        int                 i;
        int                 r;
        int                 target;
        logic [13:0]        tmpl_list[6];

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        data_byte        = '0;
        start_of_message = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_write_data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_pct   = 20;
        stall_pct = 20;

        // Directed: a full message on the reset template id, with characters
        // at both extremes and a three-byte price.
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'h86, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Ten-byte all-ones sequence number: keeps the low 63 bits, flags overflow.
        for (i = 0; i < 9; i++)
            send_byte(8'h7F, i == 0);
        send_byte(8'hFF, 1'b0);
        // Presence map, template mismatch, then a field that decodes as unknown.
        send_byte(8'h80, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h80, 1'b0);

        tmpl_list[0] = 14'd0;
        tmpl_list[1] = 14'h3FFF;
        tmpl_list[2] = 14'($urandom_range(2, 16382));
        tmpl_list[3] = 14'd127;
        tmpl_list[4] = 14'd128;
        tmpl_list[5] = 14'($urandom_range(0, 16383));

        for (ph = 0; ph < 6; ph++)
        begin
            set_template(tmpl_list[ph]);
            // vary the pressure; clean stretches mid-run and at the end
            if (ph == 3 || ph == 5)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(5, 40);
                stall_pct = $urandom_range(5, 40);
            end
            target = bytes_sent + 215;
            while (bytes_sent < target)
            begin
                r = $urandom_range(99);
                if (r < 80)
                    send_message(1'b0);
                else if (r < 90)
                    send_message(1'b1);
                else
                    send_noise();
            end
        end

        // Drain, with a limit, then let the pipe settle.
        in_valid = 1'b0;
        for (i = 0; i < 2000 && fields_pending != 0; i++)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatches == 0 && fields_pending == 0)
            $display("fast_fixed_template_field_decoder_unit: match");
        else
            $display("fast_fixed_template_field_decoder_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/fftfd_pkg.sv
rtl/fftfd_field_step.sv
rtl/fftfd_out_buffer.sv
rtl/fast_fixed_template_field_decoder_unit.sv
dv/fftfd_field_checker.sv
dv/tb_fast_fixed_template_field_decoder_unit.sv
